>>> rtl/vertex_transform_unit_macros.svh
// ----------------------------------------------------------------------------
// vertex_transform_unit_macros
// assertion helpers used by the checker file vtu_checker
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_UNIT_MACROS_SVH
`define VERTEX_TRANSFORM_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define VTU_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define VTU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vtu_pkg.sv
// ----------------------------------------------------------------------------
// vtu_pkg
// types, constants and helpers of the vertex transform unit
// ----------------------------------------------------------------------------
`default_nettype none

package vtu_pkg;

  localparam int CoordWidth   = 32;
  localparam int FracBits     = 16;
  localparam int AngleWidth   = 16;
  localparam int AngleFrac    = 14;
  localparam int ProjFrac     = 30;
  localparam int CmdWidth     = 4;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 32;
  localparam int WideWidth    = 66;

  localparam logic signed [CoordWidth-1:0] CavalierK = 32'sd759250125;
  localparam logic signed [CoordWidth-1:0] CabinetK  = 32'sd379625062;

  localparam logic signed [WideWidth-1:0] SatHi  = 66'sd2147483647;
  localparam logic signed [WideWidth-1:0] SatLo  = -66'sd2147483648;
  localparam logic signed [WideWidth-1:0] OneFix = 66'sd1 <<< FracBits;

  localparam logic [CoordWidth-1:0] MagPosLim = 32'h7fffffff;
  localparam logic [CoordWidth-1:0] MagNegLim = 32'h80000000;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [AngleWidth-1:0] angle_t;
  typedef logic [CoordWidth-1:0]        umag_t;

  typedef enum logic [CmdWidth-1:0] {
    CMD_TRANSLATE = 4'd0,
    CMD_ROT_X     = 4'd1,
    CMD_ROT_Y     = 4'd2,
    CMD_ROT_Z     = 4'd3,
    CMD_REFL_XY   = 4'd4,
    CMD_REFL_YZ   = 4'd5,
    CMD_REFL_XZ   = 4'd6,
    CMD_SCALE     = 4'd7,
    CMD_ORTHO     = 4'd8,
    CMD_CAVALIER  = 4'd9,
    CMD_CABINET   = 4'd10,
    CMD_CENTRAL   = 4'd11
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PARAM_X   = 3'd0,
    REG_PARAM_Y   = 3'd1,
    REG_PARAM_Z   = 3'd2,
    REG_COS_ANGLE = 3'd3,
    REG_SIN_ANGLE = 3'd4,
    REG_INV_DEPTH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    coord_t param_x;
    coord_t param_y;
    coord_t param_z;
    angle_t cos_angle;
    angle_t sin_angle;
    coord_t inv_depth;
  } cfg_t;

  typedef struct packed {
    cmd_e   cmd;
    coord_t x;
    coord_t y;
    coord_t z;
  } vtx_t;

  typedef struct packed {
    cmd_e                                   cmd;
    coord_t                                 x;
    coord_t                                 y;
    coord_t                                 z;
    logic signed [2*CoordWidth-1:0]         px;
    logic signed [2*CoordWidth-1:0]         py;
    logic signed [2*CoordWidth-1:0]         pz;
    logic signed [CoordWidth+AngleWidth-1:0] uc;
    logic signed [CoordWidth+AngleWidth-1:0] vs;
    logic signed [CoordWidth+AngleWidth-1:0] us;
    logic signed [CoordWidth+AngleWidth-1:0] vc;
  } prod_t;

  typedef struct packed {
    cmd_e   cmd;
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t rot_a;
    coord_t rot_b;
    coord_t sx;
    coord_t sy;
    coord_t sz;
  } mid_t;

  typedef struct packed {
    logic   central;
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t w;
  } res_t;

  typedef struct packed {
    umag_t rem;
    umag_t dvd;
    umag_t quo;
    logic  neg;
    logic  ovf;
    logic  zero;
  } lane_t;

  typedef struct packed {
    logic   central;
    logic   err;
    coord_t x;
    coord_t y;
    coord_t z;
    umag_t  mw;
    lane_t  lx;
    lane_t  ly;
  } divw_t;

  function automatic coord_t sat_coord(input logic signed [WideWidth-1:0] v);
    if (v > SatHi) return coord_t'(SatHi);
    if (v < SatLo) return coord_t'(SatLo);
    return coord_t'(v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/vtu_in_if.sv
// ----------------------------------------------------------------------------
// vtu_in_if
// vertex word channel: command and coordinates
// ----------------------------------------------------------------------------
`default_nettype none

interface vtu_in_if import vtu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CmdWidth-1:0] command;
  coord_t              x_in;
  coord_t              y_in;
  coord_t              z_in;

  modport source (output valid, command, x_in, y_in, z_in, input ready);
  modport sink   (input valid, command, x_in, y_in, z_in, output ready);
endinterface

`default_nettype wire

>>> rtl/vtu_out_if.sv
// ----------------------------------------------------------------------------
// vtu_out_if
// result word channel: transformed vertex and error flag
// ----------------------------------------------------------------------------
`default_nettype none

interface vtu_out_if import vtu_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_out;
  coord_t y_out;
  coord_t z_out;
  logic   divide_error;

  modport source (output valid, x_out, y_out, z_out, divide_error, input ready);
  modport sink   (input valid, x_out, y_out, z_out, divide_error, output ready);
endinterface

`default_nettype wire

>>> rtl/vtu_mult.sv
// ----------------------------------------------------------------------------
// vtu_mult
// product stage: scale, projection and rotation multipliers
// ----------------------------------------------------------------------------
`default_nettype none

module vtu_mult import vtu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cfg_t  cfg,
  input  logic  valid_in,
  input  vtx_t  item_in,
  output logic  valid_out,
  output prod_t item_out
);

  coord_t zb;
  coord_t u;
  coord_t v;
  prod_t  item_next;

  always_comb begin
    unique case (item_in.cmd)
      CMD_CENTRAL:  zb = cfg.inv_depth;
      CMD_CAVALIER: zb = CavalierK;
      CMD_CABINET:  zb = CabinetK;
      default:      zb = cfg.param_z;
    endcase
    // rotation operand pair, first = u*c - v*s, second = u*s + v*c
    unique case (item_in.cmd)
      CMD_ROT_X: begin u = item_in.y; v = item_in.z; end
      CMD_ROT_Y: begin u = item_in.z; v = item_in.x; end
      default:   begin u = item_in.x; v = item_in.y; end
    endcase
  end

  always_comb begin
    item_next.cmd = item_in.cmd;
    item_next.x   = item_in.x;
    item_next.y   = item_in.y;
    item_next.z   = item_in.z;
    item_next.px  = $signed(item_in.x) * $signed(cfg.param_x);
    item_next.py  = $signed(item_in.y) * $signed(cfg.param_y);
    item_next.pz  = $signed(item_in.z) * $signed(zb);
    item_next.uc  = $signed(u) * $signed(cfg.cos_angle);
    item_next.vs  = $signed(v) * $signed(cfg.sin_angle);
    item_next.us  = $signed(u) * $signed(cfg.sin_angle);
    item_next.vc  = $signed(v) * $signed(cfg.cos_angle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vtu_post.sv
// ----------------------------------------------------------------------------
// vtu_post
// rounding and saturation, per-command result, divider setup
// ----------------------------------------------------------------------------
`default_nettype none

module vtu_post import vtu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cfg_t  cfg,
  input  logic  valid_in,
  input  prod_t item_in,
  output logic  valid_out,
  output divw_t item_out
);

  logic  v3;
  logic  v4;
  mid_t  m3;
  mid_t  m3_next;
  res_t  r4;
  res_t  r4_next;
  divw_t d5_next;

  logic signed [CoordWidth+AngleWidth:0] sum_a;
  logic signed [CoordWidth+AngleWidth:0] sum_b;
  logic signed [2*CoordWidth-1:0]        pz_sh;
  logic                                  w_neg;
  umag_t                                 mw;

  function automatic lane_t lane_init(input coord_t v, input logic wn, input umag_t m);
    lane_t l;
    umag_t mx;
    mx     = v[CoordWidth-1] ? umag_t'(-v) : umag_t'(v);
    l.rem  = umag_t'(mx >> FracBits);
    l.dvd  = umag_t'(mx << (CoordWidth - FracBits));
    l.quo  = '0;
    l.neg  = v[CoordWidth-1] ^ wn;
    l.ovf  = umag_t'(mx >> FracBits) >= m;
    l.zero = (mx == '0);
    return l;
  endfunction

  // stage 3: round products by floor and saturate
  always_comb begin
    sum_a = (CoordWidth+AngleWidth+1)'($signed(item_in.uc))
          - (CoordWidth+AngleWidth+1)'($signed(item_in.vs));
    sum_b = (CoordWidth+AngleWidth+1)'($signed(item_in.us))
          + (CoordWidth+AngleWidth+1)'($signed(item_in.vc));
    if (item_in.cmd == CMD_CAVALIER || item_in.cmd == CMD_CABINET) begin
      pz_sh = $signed(item_in.pz) >>> ProjFrac;
    end else begin
      pz_sh = $signed(item_in.pz) >>> FracBits;
    end
    m3_next.cmd   = item_in.cmd;
    m3_next.x     = item_in.x;
    m3_next.y     = item_in.y;
    m3_next.z     = item_in.z;
    m3_next.rot_a = sat_coord(WideWidth'(sum_a >>> AngleFrac));
    m3_next.rot_b = sat_coord(WideWidth'(sum_b >>> AngleFrac));
    m3_next.sx    = sat_coord(WideWidth'($signed(item_in.px) >>> FracBits));
    m3_next.sy    = sat_coord(WideWidth'($signed(item_in.py) >>> FracBits));
    m3_next.sz    = sat_coord(WideWidth'(pz_sh));
  end

  // stage 4: per-command result, weight for central projection
  always_comb begin
    r4_next.central = 1'b0;
    r4_next.x       = m3.x;
    r4_next.y       = m3.y;
    r4_next.z       = m3.z;
    r4_next.w       = '0;
    case (m3.cmd)
      CMD_TRANSLATE: begin
        r4_next.x = sat_coord(WideWidth'($signed(m3.x)) + WideWidth'($signed(cfg.param_x)));
        r4_next.y = sat_coord(WideWidth'($signed(m3.y)) + WideWidth'($signed(cfg.param_y)));
        r4_next.z = sat_coord(WideWidth'($signed(m3.z)) + WideWidth'($signed(cfg.param_z)));
      end
      CMD_ROT_X: begin
        r4_next.y = m3.rot_a;
        r4_next.z = m3.rot_b;
      end
      CMD_ROT_Y: begin
        r4_next.z = m3.rot_a;
        r4_next.x = m3.rot_b;
      end
      CMD_ROT_Z: begin
        r4_next.x = m3.rot_a;
        r4_next.y = m3.rot_b;
      end
      CMD_REFL_XY: r4_next.z = sat_coord(-WideWidth'($signed(m3.z)));
      CMD_REFL_YZ: r4_next.x = sat_coord(-WideWidth'($signed(m3.x)));
      CMD_REFL_XZ: r4_next.y = sat_coord(-WideWidth'($signed(m3.y)));
      CMD_SCALE: begin
        r4_next.x = m3.sx;
        r4_next.y = m3.sy;
        r4_next.z = m3.sz;
      end
      CMD_ORTHO: r4_next.z = '0;
      CMD_CAVALIER, CMD_CABINET: begin
        r4_next.x = sat_coord(WideWidth'($signed(m3.x)) + WideWidth'($signed(m3.sz)));
        r4_next.y = sat_coord(WideWidth'($signed(m3.y)) + WideWidth'($signed(m3.sz)));
        r4_next.z = '0;
      end
      CMD_CENTRAL: begin
        r4_next.central = 1'b1;
        r4_next.z       = '0;
        r4_next.w       = sat_coord(OneFix - WideWidth'($signed(m3.sz)));
      end
      default: ;
    endcase
  end

  // stage 5: magnitudes and first partial remainder for the divider
  always_comb begin
    w_neg           = r4.w[CoordWidth-1];
    mw              = w_neg ? umag_t'(-r4.w) : umag_t'(r4.w);
    d5_next.central = r4.central;
    d5_next.err     = r4.central && (r4.w == '0);
    d5_next.x       = r4.x;
    d5_next.y       = r4.y;
    d5_next.z       = r4.z;
    d5_next.mw      = mw;
    d5_next.lx      = lane_init(r4.x, w_neg, mw);
    d5_next.ly      = lane_init(r4.y, w_neg, mw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v3        <= valid_in;
      v4        <= v3;
      valid_out <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3       <= m3_next;
      r4       <= r4_next;
      item_out <= d5_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vtu_div_step.sv
// ----------------------------------------------------------------------------
// vtu_div_step
// one restoring division step on both lanes, registered
// ----------------------------------------------------------------------------
`default_nettype none

module vtu_div_step import vtu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  valid_in,
  input  divw_t item_in,
  output logic  valid_out,
  output divw_t item_out
);

  divw_t item_next;

  function automatic lane_t step(input lane_t l, input umag_t m);
    lane_t                 n;
    logic [CoordWidth:0]   sh;
    sh    = {l.rem, l.dvd[CoordWidth-1]};
    n     = l;
    n.dvd = {l.dvd[CoordWidth-2:0], 1'b0};
    if (sh >= {1'b0, m}) begin
      n.rem = CoordWidth'(sh - {1'b0, m});
      n.quo = {l.quo[CoordWidth-2:0], 1'b1};
    end else begin
      n.rem = sh[CoordWidth-1:0];
      n.quo = {l.quo[CoordWidth-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    item_next    = item_in;
    item_next.lx = step(item_in.lx, item_in.mw);
    item_next.ly = step(item_in.ly, item_in.mw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/vertex_transform_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_unit
// homogeneous 3d vertex transform, without result stalls one vertex per clock
// ----------------------------------------------------------------------------
// Takes one vertex word per cycle while not stalled (command plus signed
// Q16.16 x, y, z) and returns one result word per vertex, in order. The
// pipeline is: input register, multiplier stage, three rounding / select /
// divider setup stages, 32 bit-serial divider stages for central projection
// (one quotient bit each, x and y side by side) and the output register. A
// full pipeline holds 38 words; when the result side stalls, the whole
// pipeline holds and vertex.ready drops in the same cycle, so nothing is
// lost or repeated. Configuration registers (offsets or scale factors, Q2.14
// cosine and sine, 1/z0) must be written through cfg_we / cfg_index /
// cfg_data only while no vertex is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_unit import vtu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  vtu_in_if.sink                  vertex,
  vtu_out_if.source               result,
  input  logic                    cfg_we,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  localparam int DivSteps = CoordWidth;

  // configuration registers
  cfg_t cfg;

  // pipeline advance: the whole pipe moves when the output slot is empty or its word is taken
  logic adv;

  // stage 1: input register
  logic v1;
  vtx_t s1;

  // stage 2: products
  logic  v2;
  prod_t s2;

  // divider chain, entry 0 is the setup stage
  logic  dv [0:DivSteps];
  divw_t dd [0:DivSteps];

  // output register
  logic   v_out;
  coord_t x_q;
  coord_t y_q;
  coord_t z_q;
  logic   err_q;
  coord_t x_res;
  coord_t y_res;

  // finish one divider lane: zero, saturate or apply the sign
  function automatic coord_t lane_result(input lane_t l);
    umag_t lim;
    umag_t m;
    lim = l.neg ? MagNegLim : MagPosLim;
    m   = (l.ovf || l.quo > lim) ? lim : l.quo;
    if (l.zero) return '0;
    return l.neg ? coord_t'(-m) : coord_t'(m);
  endfunction

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.param_x   <= '0;
      cfg.param_y   <= '0;
      cfg.param_z   <= '0;
      cfg.cos_angle <= 16'sd16384;
      cfg.sin_angle <= '0;
      cfg.inv_depth <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_index))
        REG_PARAM_X:   cfg.param_x   <= coord_t'(cfg_data);
        REG_PARAM_Y:   cfg.param_y   <= coord_t'(cfg_data);
        REG_PARAM_Z:   cfg.param_z   <= coord_t'(cfg_data);
        REG_COS_ANGLE: cfg.cos_angle <= angle_t'(cfg_data[AngleWidth-1:0]);
        REG_SIN_ANGLE: cfg.sin_angle <= angle_t'(cfg_data[AngleWidth-1:0]);
        REG_INV_DEPTH: cfg.inv_depth <= coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  assign adv          = !v_out || result.ready;
  assign vertex.ready = adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= vertex.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.cmd <= cmd_e'(vertex.command);
      s1.x   <= vertex.x_in;
      s1.y   <= vertex.y_in;
      s1.z   <= vertex.z_in;
    end
  end

  // multipliers
  vtu_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .cfg       (cfg),
    .valid_in  (v1),
    .item_in   (s1),
    .valid_out (v2),
    .item_out  (s2)
  );

  // rounding, per-command select and divider setup
  vtu_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .cfg       (cfg),
    .valid_in  (v2),
    .item_in   (s2),
    .valid_out (dv[0]),
    .item_out  (dd[0])
  );

  // one quotient bit per stage for central projection
  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    vtu_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .valid_in  (dv[k]),
      .item_in   (dd[k]),
      .valid_out (dv[k+1]),
      .item_out  (dd[k+1])
    );
  end

  assign x_res = dd[DivSteps].central ? lane_result(dd[DivSteps].lx) : dd[DivSteps].x;
  assign y_res = dd[DivSteps].central ? lane_result(dd[DivSteps].ly) : dd[DivSteps].y;

  // output register, holds its word while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= dv[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_q   <= x_res;
      y_q   <= y_res;
      z_q   <= dd[DivSteps].z;
      err_q <= dd[DivSteps].err;
    end
  end

  assign result.valid        = v_out;
  assign result.x_out        = x_q;
  assign result.y_out        = y_q;
  assign result.z_out        = z_q;
  assign result.divide_error = err_q;

endmodule

`default_nettype wire

>>> rtl/vtu_checker.sv
// ----------------------------------------------------------------------------
// vtu_checker
// port-level checks of the vertex transform unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "vertex_transform_unit_macros.svh"

module vtu_checker import vtu_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire coord_t x_out,
  input wire coord_t y_out,
  input wire coord_t z_out,
  input wire logic   divide_error
);

  // a waiting result word holds still
  `VTU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(x_out) && $stable(y_out) && $stable(z_out) && $stable(divide_error), "result word changed while stalled")

  // an empty output slot always lets a vertex in
  `VTU_ASSERT_IMPL(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input blocked with empty output")

  // a stalled output holds the whole pipe
  `VTU_ASSERT_IMPL(a_stall_blocks, clk, rst, out_valid && !out_ready, !in_ready, "input taken during output stall")

  // zero weight gives edge values and z of zero
  `VTU_ASSERT_IMPL(a_div_err_edges, clk, rst, out_valid && divide_error, z_out == 32'h0 && (x_out == 32'h7fffffff || x_out == 32'h80000000 || x_out == 32'h0) && (y_out == 32'h7fffffff || y_out == 32'h80000000 || y_out == 32'h0), "divide error with non-edge output")

endmodule

bind vertex_transform_unit vtu_checker u_vtu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (vertex.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .x_out        (result.x_out),
  .y_out        (result.y_out),
  .z_out        (result.z_out),
  .divide_error (result.divide_error)
);

`default_nettype wire
